### rtl/fud_pkg.sv
package fud_pkg;

   localparam int unsigned HEADER_BYTES = 38;
   localparam int unsigned CHUNK_BYTES  = 200;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned POS_W   = 24;
   localparam int unsigned SIZE_W  = 32;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned KIND_W  = 2;

   localparam logic [BYTE_W-1:0] START_LOCAL = 8'h01;
   localparam logic [BYTE_W-1:0] START_MESH  = 8'h02;

   localparam int unsigned RSP_DATA_W = 88;
   localparam int unsigned RSP_USER_W = 3;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_HEADER = 2'd1,
      PH_CHUNK  = 2'd2
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      EV_START  = 2'd0,
      EV_HEADER = 2'd1,
      EV_IMAGE  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type               event_kind;
      logic                   mesh_mode;
      logic [BYTE_W-1:0]      data_byte;
      logic [POS_W-1:0]       byte_position;
      logic [SIZE_W-1:0]      image_size;
      logic [COUNT_W-1:0]     chunk_total;
      logic                   chunk_done;
      logic                   transfer_done;
      logic                   receiving;
   } rsp_type;

endpackage

### rtl/fud_core.sv
module fud_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [fud_pkg::BYTE_W-1:0] rx_byte,
   output logic                       produce,
   output fud_pkg::rsp_type           rsp
);
   import fud_pkg::*;

   localparam logic [BYTE_W:0] HDR_LAST = (BYTE_W+1)'(HEADER_BYTES);
   localparam logic [BYTE_W:0] CHK_LAST = (BYTE_W+1)'(CHUNK_BYTES);
   localparam logic [POS_W-1:0] CHK_STEP = POS_W'(CHUNK_BYTES);

   phase_type           phase_ff, phase_in;
   logic                mesh_ff, mesh_in;
   logic                busy_ff, busy_in;
   logic [BYTE_W-1:0]   count_ff, count_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [COUNT_W-1:0]  chunk_ff, chunk_in;
   logic [POS_W-1:0]    base_ff, base_in;

   logic                is_start;
   logic                hdr_end;
   logic                chk_end;
   logic                last_chunk;
   logic [COUNT_W-1:0]  chunk_next;

   assign is_start   = (rx_byte == START_LOCAL) || (rx_byte == START_MESH);
   assign hdr_end    = ({1'b0, count_ff} + 1'b1) >= HDR_LAST;
   assign chk_end    = ({1'b0, count_ff} + 1'b1) >= CHK_LAST;
   assign chunk_next = chunk_ff + 1'b1;
   assign last_chunk = chunk_next >= total_ff;

   // next state
   always_comb begin
      phase_in = phase_ff;
      mesh_in  = mesh_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      size_in  = size_ff;
      total_in = total_ff;
      chunk_in = chunk_ff;
      base_in  = base_ff;
      case (phase_ff)
         PH_HEADER: begin
            if (count_ff < BYTE_W'(4)) begin
               case (count_ff[1:0])
                  2'd0:    size_in[7:0]   = rx_byte;
                  2'd1:    size_in[15:8]  = rx_byte;
                  2'd2:    size_in[23:16] = rx_byte;
                  default: size_in[31:24] = rx_byte;
               endcase
            end else if (count_ff < BYTE_W'(6)) begin
               if (count_ff[0]) begin
                  total_in[15:8] = rx_byte;
               end else begin
                  total_in[7:0] = rx_byte;
               end
            end
            count_in = count_ff + 1'b1;
            if (hdr_end) begin
               phase_in = PH_CHUNK;
               chunk_in = '0;
               base_in  = '0;
               count_in = '0;
            end
         end
         PH_CHUNK: begin
            count_in = count_ff + 1'b1;
            if (chk_end) begin
               count_in = '0;
               chunk_in = chunk_next;
               base_in  = base_ff + CHK_STEP;
               if (last_chunk) begin
                  busy_in  = 1'b0;
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
            if (is_start) begin
               mesh_in  = (rx_byte == START_MESH);
               busy_in  = 1'b1;
               phase_in = PH_HEADER;
               count_in = '0;
            end
         end
      endcase
   end

   // result
   always_comb begin
      produce = 1'b0;
      rsp     = '0;
      case (phase_ff)
         PH_HEADER: begin
            produce           = 1'b1;
            rsp.event_kind    = EV_HEADER;
            rsp.mesh_mode     = mesh_ff;
            rsp.data_byte     = rx_byte;
            rsp.byte_position = POS_W'(count_ff);
            rsp.receiving     = busy_ff;
         end
         PH_CHUNK: begin
            produce           = 1'b1;
            rsp.event_kind    = EV_IMAGE;
            rsp.mesh_mode     = mesh_ff;
            rsp.data_byte     = rx_byte;
            rsp.byte_position = base_ff + POS_W'(count_ff);
            rsp.image_size    = size_ff;
            rsp.chunk_total   = total_ff;
            rsp.chunk_done    = chk_end;
            rsp.transfer_done = chk_end && last_chunk;
            rsp.receiving     = busy_in;
         end
         default: begin
            produce        = is_start;
            rsp.event_kind = EV_START;
            rsp.mesh_mode  = (rx_byte == START_MESH);
            rsp.receiving  = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mesh_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         count_ff <= '0;
         size_ff  <= '0;
         total_ff <= '0;
         chunk_ff <= '0;
         base_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         mesh_ff  <= mesh_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
         size_ff  <= size_in;
         total_ff <= total_in;
         chunk_ff <= chunk_in;
         base_ff  <= base_in;
      end
   end

endmodule

### rtl/firmware_upload_deframer_unit.sv
// Firmware upload deframer: takes one serial byte per transfer on req_ and
// emits at most one event per byte on rsp_ (transfer start, header byte with
// its index, or image byte with its absolute address and chunk markers).
// A byte passes an input register, then a single step of phase and counter
// logic into the result register; rsp_ is driven from that result register,
// so a result sits behind both registers. One byte per cycle is sustained
// while rsp_tready stays high; a stalled result register holds the input
// register and drops req_tready. Image addresses come from a running chunk
// base, no multiplier.
module firmware_upload_deframer_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,  // rx_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // data_byte, byte_position, image_size, chunk_total, chunk_done, receiving
   output logic [fud_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // event_kind, mesh_mode
   output logic [fud_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                           rsp_tlast   // transfer_done
);
   import fud_pkg::*;

   logic               in_vld_ff;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               rsp_vld_ff;
   rsp_type            rsp_ff;
   logic               advance;
   logic               produce;
   rsp_type            rsp_in;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;

   fud_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .produce (produce),
      .rsp     (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= produce;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produce) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tlast  = rsp_ff.transfer_done;
   assign rsp_tuser  = {rsp_ff.mesh_mode, rsp_ff.event_kind};
   assign rsp_tdata  = {6'd0, rsp_ff.receiving, rsp_ff.chunk_done, rsp_ff.chunk_total,
                        rsp_ff.image_size, rsp_ff.byte_position, rsp_ff.data_byte};

endmodule

### rtl/fud_checker.sv
module fud_assertions (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [fud_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [fud_pkg::RSP_USER_W-1:0] rsp_tuser,
   input logic                           rsp_tlast
);
   import fud_pkg::*;

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |->
         rsp_tuser[1:0] == EV_IMAGE && rsp_tdata[80] && !rsp_tdata[81])
      else $error("transfer end without chunk end or still receiving");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == EV_START |->
         rsp_tdata[81] && rsp_tdata[31:0] == 32'd0 && !rsp_tlast)
      else $error("malformed start event");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == EV_HEADER |->
         rsp_tdata[31:8] < POS_W'(HEADER_BYTES) && rsp_tdata[80] == 1'b0)
      else $error("header index out of range");

endmodule

bind firmware_upload_deframer_unit fud_assertions u_fud_checker (.*);
